// File: hdl/c_comment_stripper_top_macros.svh
// Assertion macros shared by the comment stripper RTL.
`ifndef C_COMMENT_STRIPPER_TOP_MACROS_SVH
`define C_COMMENT_STRIPPER_TOP_MACROS_SVH

// Check that a property holds on every rising clock edge outside reset.
`define CCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define CCS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// File: hdl/ccs_pkg.sv
// Shared types and constants for the comment stripper.
package ccs_pkg;

    localparam int CCS_QDEPTH = 4;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_STRING = 2'd1,
        MODE_BLOCK  = 2'd2,
        MODE_LINE   = 2'd3
    } t_mode;

    // One input byte's worth of output: one or two bytes, b0 first.
    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: hdl/ccs_front.sv
// Scanner: tracks comment and literal state and classifies each byte.
module ccs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_byte,
    input  logic           i_line_end,
    output logic           o_push,
    output ccs_pkg::t_entry o_entry
);
    import ccs_pkg::*;

    t_mode r_mode, n_mode;
    logic  r_single, n_single;
    logic  r_esc, n_esc;
    logic  r_slash, n_slash;
    logic  r_star, n_star;

    logic is_star, is_slash, is_quote, quote_close, emit_plain;

    always_comb begin
        is_star     = (i_byte == CH_STAR);
        is_slash    = (i_byte == CH_SLASH);
        is_quote    = (i_byte == CH_DQUOTE) || (i_byte == CH_SQUOTE);
        quote_close = r_single ? (i_byte == CH_SQUOTE) : (i_byte == CH_DQUOTE);
        // a slash not at line end waits for the next byte
        emit_plain  = !(is_slash && !i_line_end);
    end

    // next state
    always_comb begin
        n_mode   = r_mode;
        n_single = r_single;
        n_esc    = r_esc;
        n_slash  = r_slash;
        n_star   = r_star;
        unique case (r_mode)
            MODE_BLOCK: begin
                if (r_star && is_slash) begin
                    n_mode = MODE_NORMAL;
                    n_star = 1'b0;
                end else begin
                    n_star = is_star;
                end
            end
            MODE_LINE: begin
            end
            MODE_STRING: begin
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if (i_byte == CH_BSLASH) begin
                    n_esc = 1'b1;
                end else if (quote_close) begin
                    n_mode = MODE_NORMAL;
                end
            end
            default: begin
                n_slash = 1'b0;
                if (r_slash && is_slash) begin
                    n_mode = MODE_LINE;
                end else if (r_slash && is_star) begin
                    n_mode = MODE_BLOCK;
                    n_star = 1'b0;
                end else if (is_quote) begin
                    n_mode   = MODE_STRING;
                    n_single = (i_byte == CH_SQUOTE);
                    n_esc    = 1'b0;
                end else if (is_slash && !i_line_end) begin
                    n_slash = 1'b1;
                end
            end
        endcase
        if (i_line_end) begin
            if (n_mode == MODE_STRING || n_mode == MODE_LINE) begin
                n_mode = MODE_NORMAL;
            end
            n_esc   = 1'b0;
            n_slash = 1'b0;
            n_star  = 1'b0;
        end
    end

    // outputs
    always_comb begin
        o_push   = 1'b0;
        o_entry  = '{two: 1'b0, b0: i_byte, b1: i_byte};
        unique case (r_mode)
            MODE_BLOCK: begin
                o_push = !(r_star && is_slash) && (i_byte == CH_NL);
            end
            MODE_LINE: begin
                o_push = i_line_end && (i_byte == CH_NL);
            end
            MODE_STRING: begin
                o_push = 1'b1;
            end
            default: begin
                if (r_slash && is_slash) begin
                    o_push = 1'b0;
                end else if (r_slash && is_star) begin
                    o_push     = 1'b1;
                    o_entry.b0 = CH_SPACE;
                end else if (r_slash) begin
                    // release the held slash, then the byte if it is not held itself
                    o_push      = 1'b1;
                    o_entry.b0  = CH_SLASH;
                    o_entry.two = emit_plain;
                end else begin
                    o_push = emit_plain;
                end
            end
        endcase
        o_push = o_push && i_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NORMAL;
            r_single <= 1'b0;
            r_esc    <= 1'b0;
            r_slash  <= 1'b0;
            r_star   <= 1'b0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_single <= n_single;
            r_esc    <= n_esc;
            r_slash  <= n_slash;
            r_star   <= n_star;
        end
    end

endmodule

// File: hdl/ccs_queue.sv
// Short queue of classified entries between scanner and emitter.
module ccs_queue #(
    parameter int QDEPTH = ccs_pkg::CCS_QDEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ccs_pkg::t_entry  i_entry,
    input  logic             i_pop,
    output ccs_pkg::t_entry  o_head,
    output ccs_pkg::t_q_stat o_stat
);
    import ccs_pkg::*;

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QDEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QDEPTH);

    t_entry        r_mem [QDEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    always_comb begin
        o_stat.full  = (r_count == FULL_CNT);
        o_stat.empty = (r_count == '0);
        do_push = i_push && !o_stat.full;
        do_pop  = i_pop && !o_stat.empty;
        n_wptr  = do_push ? ((r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1) : r_wptr;
        n_rptr  = do_pop  ? ((r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1) : r_rptr;
        n_count = r_count + CW'(do_push) - CW'(do_pop);
        o_head  = r_mem[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

// File: hdl/ccs_back.sv
// Emitter: sends one or two bytes per queued entry.
module ccs_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ccs_pkg::t_entry  i_head,
    input  ccs_pkg::t_q_stat i_stat,
    input  logic             i_ready,
    output logic             o_valid,
    output logic [7:0]       o_byte,
    output logic             o_last,
    output logic             o_pop
);
    import ccs_pkg::*;

    logic r_phase, n_phase;
    logic xfer;

    always_comb begin
        o_valid = !i_stat.empty;
        o_byte  = r_phase ? i_head.b1 : i_head.b0;
        o_last  = !i_head.two || r_phase;
        xfer    = o_valid && i_ready;
        // drop the entry after its last byte
        o_pop   = xfer && o_last;
        n_phase = xfer ? !o_last : r_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else begin
            r_phase <= n_phase;
        end
    end

endmodule

// File: hdl/c_comment_stripper_top.sv
// Top level of the C comment stripper.
// Strips C comments from a byte stream: one input byte per cycle, tlast on the
// last byte of each line; each input byte gives zero, one or two output bytes,
// with tlast on the last output byte of each input byte. The scanner takes one
// byte per cycle whenever the entry queue (QDEPTH entries) has room; the
// emitter sends one byte per cycle while the sink is ready, so an input byte
// that releases a held slash together with itself takes two output transfers,
// which the queue absorbs. Each entry is registered in the queue on its way out.
`include "c_comment_stripper_top_macros.svh"
module c_comment_stripper_top #(
    parameter int QDEPTH = ccs_pkg::CCS_QDEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,   // line_end
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast    // run_last
);
    import ccs_pkg::*;

    logic    s_accept;
    logic    push, pop;
    t_entry  entry, head;
    t_q_stat q_stat;

    assign o_s_tready = !q_stat.full;
    assign s_accept   = i_s_tvalid && o_s_tready;

    ccs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (s_accept),
        .i_byte     (i_s_tdata),
        .i_line_end (i_s_tlast),
        .o_push     (push),
        .o_entry    (entry)
    );

    ccs_queue #(
        .QDEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    ccs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_stat  (q_stat),
        .i_ready (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_byte  (o_m_tdata),
        .o_last  (o_m_tlast),
        .o_pop   (pop)
    );

    `CCS_NEVER(a_push_full, push && q_stat.full, "entry pushed into full queue")
    `CCS_ASSERT(a_second_follows, (o_m_tvalid && i_m_tready && !o_m_tlast) |=> o_m_tvalid, "second byte missing")
    `CCS_ASSERT(a_single_last, (o_m_tvalid && !head.two) |-> o_m_tlast, "single-byte entry without tlast")
    `CCS_NEVER(a_pop_empty, pop && q_stat.empty, "pop from empty queue")

endmodule
